[design/aabb_pkg.sv]
// types and constants shared by the box subtraction pipeline
// no dependencies
`timescale 1ns / 1ps

package aabb_pkg;

    typedef logic signed [31:0] coord_t;

    // index 0 is x, 1 is y, 2 is z
    typedef struct packed {
        coord_t [2:0] hi;
        coord_t [2:0] lo;
    } box_t;

    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    typedef enum logic [2:0] {
        SIDE_POS_X     = 3'd0,
        SIDE_NEG_X     = 3'd1,
        SIDE_POS_Y     = 3'd2,
        SIDE_NEG_Y     = 3'd3,
        SIDE_POS_Z     = 3'd4,
        SIDE_NEG_Z     = 3'd5,
        SIDE_UNTOUCHED = 3'd6
    } side_t;

    localparam int PIECE_CNT = 7;

    // one bit per side_t code
    typedef logic [PIECE_CNT-1:0] mask_t;

    localparam mask_t MASK_NONE      = '0;
    localparam mask_t MASK_UNTOUCHED = mask_t'(1) << SIDE_UNTOUCHED;

    // first stage result
    typedef struct packed {
        box_t a;
        box_t ov;
        logic covered;
    } ovl_t;

    // second stage result
    typedef struct packed {
        box_t  a;
        box_t  ov;
        mask_t mask;
    } cls_t;

endpackage

[design/aabb_overlap.sv]
// stage 1: overlap box of a and b, and containment of a in b
// depends on aabb_pkg
`timescale 1ns / 1ps

module aabb_overlap import aabb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  box_t box_a,
    input  box_t box_b,
    output logic out_valid,
    input  logic out_ready,
    output ovl_t out_data
);

    logic valid_reg;
    ovl_t data_reg;
    ovl_t data_next;

    always_comb begin
        data_next.a       = box_a;
        data_next.covered = 1'b1;
        for (int k = 0; k < 3; k++) begin
            data_next.ov.lo[k] = ($signed(box_a.lo[k]) > $signed(box_b.lo[k])) ?
                                 box_a.lo[k] : box_b.lo[k];
            data_next.ov.hi[k] = ($signed(box_a.hi[k]) < $signed(box_b.hi[k])) ?
                                 box_a.hi[k] : box_b.hi[k];
            if (!(($signed(box_b.lo[k]) <= $signed(box_a.lo[k])) &&
                  ($signed(box_a.hi[k]) <= $signed(box_b.hi[k])))) begin
                data_next.covered = 1'b0;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[design/aabb_classify.sv]
// stage 2: overlap emptiness and the set of sides to emit
// depends on aabb_pkg
`timescale 1ns / 1ps

module aabb_classify import aabb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  ovl_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output cls_t out_data
);

    logic valid_reg;
    cls_t data_reg;
    cls_t data_next;
    logic ov_ok;
    mask_t cut;

    always_comb begin
        ov_ok = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (!($signed(in_data.ov.lo[k]) < $signed(in_data.ov.hi[k]))) begin
                ov_ok = 1'b0;
            end
        end
        cut = MASK_NONE;
        cut[SIDE_POS_X] = $signed(in_data.ov.hi[AX_X]) < $signed(in_data.a.hi[AX_X]);
        cut[SIDE_NEG_X] = $signed(in_data.ov.lo[AX_X]) > $signed(in_data.a.lo[AX_X]);
        cut[SIDE_POS_Y] = $signed(in_data.ov.hi[AX_Y]) < $signed(in_data.a.hi[AX_Y]);
        cut[SIDE_NEG_Y] = $signed(in_data.ov.lo[AX_Y]) > $signed(in_data.a.lo[AX_Y]);
        cut[SIDE_POS_Z] = $signed(in_data.ov.hi[AX_Z]) < $signed(in_data.a.hi[AX_Z]);
        cut[SIDE_NEG_Z] = $signed(in_data.ov.lo[AX_Z]) > $signed(in_data.a.lo[AX_Z]);

        data_next.a  = in_data.a;
        data_next.ov = in_data.ov;
        // a cut side always has positive extent once the overlap is non-empty
        if (!ov_ok) begin
            data_next.mask = MASK_UNTOUCHED;
        end else if (in_data.covered) begin
            data_next.mask = MASK_NONE;
        end else begin
            data_next.mask = cut;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[design/aabb_split.sv]
// stage 3: walks the side mask, one piece per cycle while m_ready does not stall, into the output register
// depends on aabb_pkg
`timescale 1ns / 1ps

module aabb_split import aabb_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  cls_t  in_data,
    output logic  m_valid,
    input  logic  m_ready,
    output box_t  m_piece,
    output side_t m_side,
    output logic  m_last
);

    mask_t mask_reg;
    box_t  a_reg;
    box_t  ov_reg;
    logic  m_valid_reg;
    box_t  piece_reg;
    side_t side_reg;
    logic  last_reg;

    mask_t rest;
    side_t cur_side;
    box_t  cur_piece;
    logic  out_load;
    logic  emit;

    always_comb begin
        rest     = mask_reg & (mask_reg - mask_t'(1));
        cur_side = SIDE_UNTOUCHED;
        for (int k = PIECE_CNT - 1; k >= 0; k--) begin
            if (mask_reg[k]) begin
                cur_side = side_t'(3'(k));
            end
        end
        cur_piece = a_reg;
        case (cur_side)
            SIDE_POS_X: begin
                cur_piece.lo[AX_X] = ov_reg.hi[AX_X];
            end
            SIDE_NEG_X: begin
                cur_piece.hi[AX_X] = ov_reg.lo[AX_X];
            end
            SIDE_POS_Y: begin
                cur_piece.lo[AX_X] = ov_reg.lo[AX_X];
                cur_piece.hi[AX_X] = ov_reg.hi[AX_X];
                cur_piece.lo[AX_Y] = ov_reg.hi[AX_Y];
            end
            SIDE_NEG_Y: begin
                cur_piece.lo[AX_X] = ov_reg.lo[AX_X];
                cur_piece.hi[AX_X] = ov_reg.hi[AX_X];
                cur_piece.hi[AX_Y] = ov_reg.lo[AX_Y];
            end
            SIDE_POS_Z: begin
                cur_piece          = ov_reg;
                cur_piece.lo[AX_Z] = ov_reg.hi[AX_Z];
                cur_piece.hi[AX_Z] = a_reg.hi[AX_Z];
            end
            SIDE_NEG_Z: begin
                cur_piece          = ov_reg;
                cur_piece.lo[AX_Z] = a_reg.lo[AX_Z];
                cur_piece.hi[AX_Z] = ov_reg.lo[AX_Z];
            end
            default: begin
                cur_piece = a_reg;
            end
        endcase
    end

    assign out_load = !m_valid_reg || m_ready;
    assign emit     = (mask_reg != MASK_NONE) && out_load;
    assign in_ready = (mask_reg == MASK_NONE) || (emit && (rest == MASK_NONE));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= MASK_NONE;
        end else if (in_ready && in_valid) begin
            mask_reg <= in_data.mask;
        end else if (emit) begin
            mask_reg <= rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            a_reg  <= in_data.a;
            ov_reg <= in_data.ov;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            piece_reg <= cur_piece;
            side_reg  <= cur_side;
            last_reg  <= (rest == MASK_NONE);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_piece = piece_reg;
    assign m_side  = side_reg;
    assign m_last  = last_reg;

`ifndef NO_ASSERTIONS
    a_untouched_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        mask_reg[SIDE_UNTOUCHED] |-> (mask_reg[SIDE_NEG_Z:SIDE_POS_X] == '0))
        else $error("untouched word mixed with cut sides");

    a_untouched_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (side_reg == SIDE_UNTOUCHED)) |-> last_reg)
        else $error("untouched word not marked last");

    a_piece_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (side_reg != SIDE_UNTOUCHED)) |->
            (($signed(piece_reg.lo[AX_X]) < $signed(piece_reg.hi[AX_X])) &&
             ($signed(piece_reg.lo[AX_Y]) < $signed(piece_reg.hi[AX_Y])) &&
             ($signed(piece_reg.lo[AX_Z]) < $signed(piece_reg.hi[AX_Z]))))
        else $error("emitted piece has empty extent");

    a_emit_side_in_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (m_valid_reg && $past(mask_reg[cur_side])))
        else $error("emitted side not taken from mask");
`endif

endmodule

[design/aabb_box_subtract.sv]
// top level: box a minus box b as up to six slabs (or a itself if they miss), three-stage pipeline
// depends on aabb_pkg, aabb_overlap, aabb_classify, aabb_split
`timescale 1ns / 1ps

// channel  direction  handshake            payload
// s_       in         s_valid / s_ready    s_a_min/max_x/y/z, s_b_min/max_x/y/z
// m_       out        m_valid / m_ready    m_piece_min/max_x/y/z, m_piece_side, m_last_piece
//
// the first word passes the overlap, classify and split mask registers, then the output register
// one output word per cycle while m_ready does not stall; an input pair holds the split stage
// until its last word, if any, is loaded into the single output register
// aresetn clears all valid bits and the pending side mask
// a stall on m_ready backs up stage by stage with nothing lost or repeated

module aabb_box_subtract import aabb_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_a_min_x,
    input  logic signed [31:0]  s_a_min_y,
    input  logic signed [31:0]  s_a_min_z,
    input  logic signed [31:0]  s_a_max_x,
    input  logic signed [31:0]  s_a_max_y,
    input  logic signed [31:0]  s_a_max_z,
    input  logic signed [31:0]  s_b_min_x,
    input  logic signed [31:0]  s_b_min_y,
    input  logic signed [31:0]  s_b_min_z,
    input  logic signed [31:0]  s_b_max_x,
    input  logic signed [31:0]  s_b_max_y,
    input  logic signed [31:0]  s_b_max_z,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_piece_min_x,
    output logic signed [31:0]  m_piece_min_y,
    output logic signed [31:0]  m_piece_min_z,
    output logic signed [31:0]  m_piece_max_x,
    output logic signed [31:0]  m_piece_max_y,
    output logic signed [31:0]  m_piece_max_z,
    output logic [2:0]          m_piece_side,
    output logic                m_last_piece
);

    box_t  box_a;
    box_t  box_b;
    logic  ovl_valid;
    logic  ovl_ready;
    ovl_t  ovl_data;
    logic  cls_valid;
    logic  cls_ready;
    cls_t  cls_data;
    box_t  piece;
    side_t side;

    always_comb begin
        box_a.lo[AX_X] = s_a_min_x;
        box_a.lo[AX_Y] = s_a_min_y;
        box_a.lo[AX_Z] = s_a_min_z;
        box_a.hi[AX_X] = s_a_max_x;
        box_a.hi[AX_Y] = s_a_max_y;
        box_a.hi[AX_Z] = s_a_max_z;
        box_b.lo[AX_X] = s_b_min_x;
        box_b.lo[AX_Y] = s_b_min_y;
        box_b.lo[AX_Z] = s_b_min_z;
        box_b.hi[AX_X] = s_b_max_x;
        box_b.hi[AX_Y] = s_b_max_y;
        box_b.hi[AX_Z] = s_b_max_z;
    end

    aabb_overlap u_overlap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .box_a     (box_a),
        .box_b     (box_b),
        .out_valid (ovl_valid),
        .out_ready (ovl_ready),
        .out_data  (ovl_data)
    );

    aabb_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ovl_valid),
        .in_ready  (ovl_ready),
        .in_data   (ovl_data),
        .out_valid (cls_valid),
        .out_ready (cls_ready),
        .out_data  (cls_data)
    );

    aabb_split u_split (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (cls_valid),
        .in_ready (cls_ready),
        .in_data  (cls_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_piece  (piece),
        .m_side   (side),
        .m_last   (m_last_piece)
    );

    assign m_piece_min_x = piece.lo[AX_X];
    assign m_piece_min_y = piece.lo[AX_Y];
    assign m_piece_min_z = piece.lo[AX_Z];
    assign m_piece_max_x = piece.hi[AX_X];
    assign m_piece_max_y = piece.hi[AX_Y];
    assign m_piece_max_z = piece.hi[AX_Z];
    assign m_piece_side  = side;

endmodule

[sim/aabb_box_checker.sv]
// checker for the box subtraction block: watches both channels, predicts the pieces
// of every accepted box pair and compares each result word in order
// depends on aabb_pkg
`timescale 1ns / 1ps

module aabb_box_checker import aabb_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic signed [31:0]  s_a_min_x,
    input  logic signed [31:0]  s_a_min_y,
    input  logic signed [31:0]  s_a_min_z,
    input  logic signed [31:0]  s_a_max_x,
    input  logic signed [31:0]  s_a_max_y,
    input  logic signed [31:0]  s_a_max_z,
    input  logic signed [31:0]  s_b_min_x,
    input  logic signed [31:0]  s_b_min_y,
    input  logic signed [31:0]  s_b_min_z,
    input  logic signed [31:0]  s_b_max_x,
    input  logic signed [31:0]  s_b_max_y,
    input  logic signed [31:0]  s_b_max_z,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic signed [31:0]  m_piece_min_x,
    input  logic signed [31:0]  m_piece_min_y,
    input  logic signed [31:0]  m_piece_min_z,
    input  logic signed [31:0]  m_piece_max_x,
    input  logic signed [31:0]  m_piece_max_y,
    input  logic signed [31:0]  m_piece_max_z,
    input  logic [2:0]          m_piece_side,
    input  logic                m_last_piece,
    output int                  fail_count,
    output int                  pending_cnt
);

    typedef struct packed {
        box_t  bx;
        side_t side;
        logic  last;
    } piece_t;

    piece_t pending_pieces[$];
    piece_t item_pieces[$];

    function automatic logic has_volume(box_t p);
        for (int k = 0; k < 3; k++) begin
            if (!($signed(p.lo[k]) < $signed(p.hi[k]))) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void keep_if_solid(box_t p, side_t s);
        piece_t w;
        if (has_volume(p)) begin
            w.bx   = p;
            w.side = s;
            w.last = 1'b0;
            item_pieces = {item_pieces, w};
        end
    endfunction

    function automatic string piece_text(piece_t w);
        return $sformatf("min (%0d,%0d,%0d) max (%0d,%0d,%0d) side %0d last %0d",
            $signed(w.bx.lo[AX_X]), $signed(w.bx.lo[AX_Y]), $signed(w.bx.lo[AX_Z]),
            $signed(w.bx.hi[AX_X]), $signed(w.bx.hi[AX_Y]), $signed(w.bx.hi[AX_Z]),
            w.side, w.last);
    endfunction

    // queues the pieces left of box a once box b is cut out of it
    function automatic void split_box(box_t a, box_t b);
        box_t   ov;
        box_t   p;
        logic   covered;
        piece_t w;
        covered = 1'b1;
        item_pieces.delete();
        for (int k = 0; k < 3; k++) begin
            ov.lo[k] = ($signed(a.lo[k]) > $signed(b.lo[k])) ? a.lo[k] : b.lo[k];
            ov.hi[k] = ($signed(a.hi[k]) < $signed(b.hi[k])) ? a.hi[k] : b.hi[k];
            if (!($signed(b.lo[k]) <= $signed(a.lo[k]) &&
                  $signed(a.hi[k]) <= $signed(b.hi[k]))) begin
                covered = 1'b0;
            end
        end
        // empty overlap, a passes through as is
        if (!has_volume(ov)) begin
            w.bx   = a;
            w.side = SIDE_UNTOUCHED;
            w.last = 1'b1;
            pending_pieces = {pending_pieces, w};
            return;
        end
        if (covered) begin
            return;
        end
        if ($signed(ov.hi[AX_X]) < $signed(a.hi[AX_X])) begin
            p = a;
            p.lo[AX_X] = ov.hi[AX_X];
            keep_if_solid(p, SIDE_POS_X);
        end
        if ($signed(ov.lo[AX_X]) > $signed(a.lo[AX_X])) begin
            p = a;
            p.hi[AX_X] = ov.lo[AX_X];
            keep_if_solid(p, SIDE_NEG_X);
        end
        if ($signed(ov.hi[AX_Y]) < $signed(a.hi[AX_Y])) begin
            p = a;
            p.lo[AX_X] = ov.lo[AX_X];
            p.hi[AX_X] = ov.hi[AX_X];
            p.lo[AX_Y] = ov.hi[AX_Y];
            keep_if_solid(p, SIDE_POS_Y);
        end
        if ($signed(ov.lo[AX_Y]) > $signed(a.lo[AX_Y])) begin
            p = a;
            p.lo[AX_X] = ov.lo[AX_X];
            p.hi[AX_X] = ov.hi[AX_X];
            p.hi[AX_Y] = ov.lo[AX_Y];
            keep_if_solid(p, SIDE_NEG_Y);
        end
        if ($signed(ov.hi[AX_Z]) < $signed(a.hi[AX_Z])) begin
            p = ov;
            p.lo[AX_Z] = ov.hi[AX_Z];
            p.hi[AX_Z] = a.hi[AX_Z];
            keep_if_solid(p, SIDE_POS_Z);
        end
        if ($signed(ov.lo[AX_Z]) > $signed(a.lo[AX_Z])) begin
            p = ov;
            p.lo[AX_Z] = a.lo[AX_Z];
            p.hi[AX_Z] = ov.lo[AX_Z];
            keep_if_solid(p, SIDE_NEG_Z);
        end
        for (int i = 0; i < item_pieces.size(); i++) begin
            w = item_pieces[i];
            w.last = (i == item_pieces.size() - 1);
            pending_pieces = {pending_pieces, w};
        end
    endfunction

    always @(posedge aclk) begin : monitor
        box_t   in_a;
        box_t   in_b;
        piece_t got;
        piece_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                in_a.lo[AX_X] = s_a_min_x;
                in_a.lo[AX_Y] = s_a_min_y;
                in_a.lo[AX_Z] = s_a_min_z;
                in_a.hi[AX_X] = s_a_max_x;
                in_a.hi[AX_Y] = s_a_max_y;
                in_a.hi[AX_Z] = s_a_max_z;
                in_b.lo[AX_X] = s_b_min_x;
                in_b.lo[AX_Y] = s_b_min_y;
                in_b.lo[AX_Z] = s_b_min_z;
                in_b.hi[AX_X] = s_b_max_x;
                in_b.hi[AX_Y] = s_b_max_y;
                in_b.hi[AX_Z] = s_b_max_z;
                split_box(in_a, in_b);
            end
            if (m_valid && m_ready) begin
                got.bx.lo[AX_X] = m_piece_min_x;
                got.bx.lo[AX_Y] = m_piece_min_y;
                got.bx.lo[AX_Z] = m_piece_min_z;
                got.bx.hi[AX_X] = m_piece_max_x;
                got.bx.hi[AX_Y] = m_piece_max_y;
                got.bx.hi[AX_Z] = m_piece_max_z;
                got.side        = side_t'(m_piece_side);
                got.last        = m_last_piece;
                if (pending_pieces.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result word with none pending: %s",
                            $time, piece_text(got));
                    end
                end else begin
                    want = pending_pieces.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: piece mismatch\n  expected %s\n  actual   %s",
                                $time, piece_text(want), piece_text(got));
                        end
                    end
                end
            end
        end
        pending_cnt <= pending_pieces.size();
    end

endmodule

[sim/tb_aabb_box_subtract.sv]
// testbench top for the box subtraction block: drives box pairs and random
// stalls on both channels, then gives the verdict from the checker's fail and pending counts
// depends on aabb_pkg, aabb_box_subtract, aabb_box_checker
`timescale 1ns / 1ps

module tb_aabb_box_subtract;
    import aabb_pkg::*;

    localparam int     STALL_LIMIT  = 5000;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     DRAIN_CYCLES = 20;
    localparam coord_t C_MIN        = 32'sh8000_0000;
    localparam coord_t C_MAX        = 32'sh7fff_ffff;

    typedef enum int {
        B_COVERS, B_WITHIN, B_LOW, B_HIGH, B_SAME, B_FLUSH_LO, B_FLUSH_HI,
        B_BELOW, B_ABOVE
    } axis_mix_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    coord_t      s_a_min_x     = '0;
    coord_t      s_a_min_y     = '0;
    coord_t      s_a_min_z     = '0;
    coord_t      s_a_max_x     = '0;
    coord_t      s_a_max_y     = '0;
    coord_t      s_a_max_z     = '0;
    coord_t      s_b_min_x     = '0;
    coord_t      s_b_min_y     = '0;
    coord_t      s_b_min_z     = '0;
    coord_t      s_b_max_x     = '0;
    coord_t      s_b_max_y     = '0;
    coord_t      s_b_max_z     = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    coord_t      m_piece_min_x;
    coord_t      m_piece_min_y;
    coord_t      m_piece_min_z;
    coord_t      m_piece_max_x;
    coord_t      m_piece_max_y;
    coord_t      m_piece_max_z;
    logic [2:0]  m_piece_side;
    logic        m_last_piece;
    int          fail_count;
    int          pending_cnt;
    int          send_idle     = 0;
    int          recv_idle     = 0;
    bit          hold_req      = 1'b0;
    bit          hold_done     = 1'b0;
    int          stall_cycles  = 0;

    aabb_box_subtract u_top (.*);
    aabb_box_checker  u_check (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver side, with one long hold-off when asked
    initial begin : rx_side
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic coord_t fx(int v);
        return coord_t'(v * 65536);
    endfunction

    function automatic box_t mk_box(coord_t lx, coord_t ly, coord_t lz,
                                    coord_t hx, coord_t hy, coord_t hz);
        box_t r;
        r.lo[AX_X] = lx;
        r.lo[AX_Y] = ly;
        r.lo[AX_Z] = lz;
        r.hi[AX_X] = hx;
        r.hi[AX_Y] = hy;
        r.hi[AX_Z] = hz;
        return r;
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 3))
            0, 1: return coord_t'($urandom);
            2: return fx(int'($urandom_range(0, 15)) - 8);
            default: begin
                if ($urandom_range(0, 1)) begin
                    return C_MAX - coord_t'($urandom_range(0, 3));
                end
                return C_MIN + coord_t'($urandom_range(0, 3));
            end
        endcase
    endfunction

    task automatic send_pair(input box_t a, input box_t b);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_a_min_x <= a.lo[AX_X];
        s_a_min_y <= a.lo[AX_Y];
        s_a_min_z <= a.lo[AX_Z];
        s_a_max_x <= a.hi[AX_X];
        s_a_max_y <= a.hi[AX_Y];
        s_a_max_z <= a.hi[AX_Z];
        s_b_min_x <= b.lo[AX_X];
        s_b_min_y <= b.lo[AX_Y];
        s_b_min_z <= b.lo[AX_Z];
        s_b_max_x <= b.hi[AX_X];
        s_b_max_y <= b.hi[AX_Y];
        s_b_max_z <= b.hi[AX_Z];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // one axis of a well-formed pair: four sorted values placed by a random relation
    task automatic make_axis(output coord_t alo, output coord_t ahi,
                             output coord_t blo, output coord_t bhi);
        coord_t    v[4];
        coord_t    t;
        axis_mix_t mix;
        for (int i = 0; i < 4; i++) v[i] = pick_coord();
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3 - i; j++) begin
                if (v[j] > v[j+1]) begin
                    t      = v[j];
                    v[j]   = v[j+1];
                    v[j+1] = t;
                end
            end
        end
        if ($urandom_range(0, 19) == 0) begin
            mix = $urandom_range(0, 1) ? B_BELOW : B_ABOVE;
        end else begin
            mix = axis_mix_t'($urandom_range(int'(B_COVERS), int'(B_FLUSH_HI)));
        end
        case (mix)
            B_COVERS:   begin alo = v[1]; ahi = v[2]; blo = v[0]; bhi = v[3]; end
            B_WITHIN:   begin alo = v[0]; ahi = v[3]; blo = v[1]; bhi = v[2]; end
            B_LOW:      begin alo = v[1]; ahi = v[3]; blo = v[0]; bhi = v[2]; end
            B_HIGH:     begin alo = v[0]; ahi = v[2]; blo = v[1]; bhi = v[3]; end
            B_SAME:     begin alo = v[1]; ahi = v[2]; blo = v[1]; bhi = v[2]; end
            B_FLUSH_LO: begin alo = v[0]; ahi = v[3]; blo = v[0]; bhi = v[2]; end
            B_FLUSH_HI: begin alo = v[0]; ahi = v[3]; blo = v[1]; bhi = v[3]; end
            B_BELOW:    begin alo = v[2]; ahi = v[3]; blo = v[0]; bhi = v[1]; end
            default:    begin alo = v[0]; ahi = v[1]; blo = v[2]; bhi = v[3]; end
        endcase
    endtask

    task automatic send_random(input int count);
        box_t   a;
        box_t   b;
        coord_t alo;
        coord_t ahi;
        coord_t blo;
        coord_t bhi;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 15) begin
                for (int k = 0; k < 3; k++) begin
                    a.lo[k] = coord_t'($urandom);
                    a.hi[k] = coord_t'($urandom);
                    b.lo[k] = coord_t'($urandom);
                    b.hi[k] = coord_t'($urandom);
                end
            end else begin
                for (int k = 0; k < 3; k++) begin
                    make_axis(alo, ahi, blo, bhi);
                    a.lo[k] = alo;
                    a.hi[k] = ahi;
                    b.lo[k] = blo;
                    b.hi[k] = bhi;
                end
            end
            send_pair(a, b);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_cnt != 0);
    endtask

    task automatic run_directed();
        box_t full;
        box_t cube;
        full = mk_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        cube = mk_box(fx(0), fx(0), fx(0), fx(4), fx(4), fx(4));
        // all six slabs, widest and narrowest
        send_pair(full, mk_box(fx(-1), fx(-1), fx(-1), fx(1), fx(1), fx(1)));
        send_pair(full, mk_box(C_MIN + 1, C_MIN + 1, C_MIN + 1,
                               C_MAX - 1, C_MAX - 1, C_MAX - 1));
        // containment, equal boxes and full-range b
        send_pair(cube, cube);
        send_pair(cube, full);
        send_pair(full, full);
        // no overlap: apart, touching, inverted a, flat a
        send_pair(cube, mk_box(fx(5), fx(0), fx(0), fx(9), fx(4), fx(4)));
        send_pair(cube, mk_box(fx(1), fx(4), fx(1), fx(3), fx(8), fx(3)));
        send_pair(mk_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN), cube);
        send_pair(mk_box(fx(0), fx(0), fx(2), fx(4), fx(4), fx(2)), full);
        // each side alone
        send_pair(cube, mk_box(fx(-1), fx(-1), fx(-1), fx(3), fx(5), fx(5)));
        send_pair(cube, mk_box(fx(1), fx(-1), fx(-1), fx(5), fx(5), fx(5)));
        send_pair(cube, mk_box(fx(-1), fx(-1), fx(-1), fx(5), fx(3), fx(5)));
        send_pair(cube, mk_box(fx(-1), fx(1), fx(-1), fx(5), fx(5), fx(5)));
        send_pair(cube, mk_box(fx(-1), fx(-1), fx(-1), fx(5), fx(5), fx(3)));
        send_pair(cube, mk_box(fx(-1), fx(-1), fx(1), fx(5), fx(5), fx(5)));
        // corner cut and one-lsb overlap
        send_pair(cube, mk_box(fx(2), fx(2), fx(2), fx(6), fx(6), fx(6)));
        send_pair(cube, mk_box(fx(4) - 1, fx(4) - 1, fx(4) - 1, fx(9), fx(9), fx(9)));
        // negative region and half-space b
        send_pair(mk_box(fx(-8), fx(-8), fx(-8), fx(-2), fx(-2), fx(-2)),
                  mk_box(fx(-5), fx(-9), fx(-6), fx(-4), fx(-3), fx(-1)));
        send_pair(full, mk_box(C_MIN, C_MIN, C_MIN, fx(0), fx(0), fx(0)));
        send_pair(full, mk_box(fx(0), fx(0), fx(0), C_MAX, C_MAX, C_MAX));
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 36;
        recv_idle = 61;
        run_directed();
        send_random(137);
        drain();

        send_idle = 61;
        recv_idle = 36;
        send_random(137);
        drain();

        // no idling, receiver holds off once so the pipe backs up
        send_idle = 0;
        recv_idle = 0;
        hold_req  = 1'b1;
        send_random(136);
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
design/aabb_pkg.sv
design/aabb_overlap.sv
design/aabb_classify.sv
design/aabb_split.sv
design/aabb_box_subtract.sv
sim/aabb_box_checker.sv
sim/tb_aabb_box_subtract.sv
